### rtl/core/ack_frame_range_parser_top_defines.svh
// assertion macros for the ack frame range parser, used by the result queue
`ifndef ACK_FRAME_RANGE_PARSER_TOP_DEFINES_SVH
`define ACK_FRAME_RANGE_PARSER_TOP_DEFINES_SVH

// condition must hold on every clock edge out of reset
`define AFRP_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("afrp invariant violated");

// antecedent implies consequent on the same edge
`define AFRP_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("afrp implication violated");

`endif

### rtl/core/afrp_pkg.sv
// shared types and codes for the ack frame range parser
`default_nettype none

package afrp_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_RANGE = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // error codes
  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_TYPE        = 3'd1,
    ERR_TRUNCATED   = 3'd2,
    ERR_FIRST_RANGE = 3'd3,
    ERR_COUNT       = 3'd4,
    ERR_GAP         = 3'd5,
    ERR_RANGE       = 3'd6
  } err_t;

  // frame field currently being decoded
  typedef enum logic [3:0] {
    STEP_TYPE    = 4'd0,
    STEP_LARGEST = 4'd1,
    STEP_DELAY   = 4'd2,
    STEP_COUNT   = 4'd3,
    STEP_FIRST   = 4'd4,
    STEP_GAP     = 4'd5,
    STEP_RANGE   = 4'd6,
    STEP_ECT0    = 4'd7,
    STEP_ECT1    = 4'd8,
    STEP_CE      = 4'd9
  } step_t;

  localparam int unsigned VAL_W   = 62;
  localparam int unsigned END_W   = 63;
  localparam int unsigned BCNT_W  = 13;

  // frame type values
  localparam logic [VAL_W-1:0] TYPE_ACK     = 62'h2;
  localparam logic [VAL_W-1:0] TYPE_ACK_ECN = 62'h3;

  // result queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  typedef struct packed {
    kind_t              kind;
    err_t               code;
    logic [VAL_W-1:0]   range_start;
    logic [END_W-1:0]   range_end;
    logic [VAL_W-1:0]   peak_pn;
    logic [VAL_W-1:0]   reported_delay;
    logic [VAL_W-1:0]   ect0_count;
    logic [VAL_W-1:0]   ect1_count;
    logic [VAL_W-1:0]   ce_count;
    logic [BCNT_W-1:0]  consumed_bytes;
    logic               is_last;
  } result_t;

  // results produced by one byte, in order
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

### rtl/core/afrp_parse.sv
// varint assembly and ack frame field decoding, one byte per cycle while go is high
`default_nettype none

module afrp_parse #(
  parameter int unsigned MAX_RANGES = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                go,
  input  wire logic                frame_start,
  input  wire logic [7:0]          byte_value,
  input  wire logic                buffer_end,
  output afrp_pkg::push_t          push
);

  localparam int unsigned RL_W = $clog2(MAX_RANGES + 1);
  localparam int unsigned VW   = afrp_pkg::VAL_W;
  localparam int unsigned BW   = afrp_pkg::BCNT_W;

  // frame state
  logic                active;
  afrp_pkg::step_t     field_step;
  logic [VW-1:0]       varint_acc;
  logic [2:0]          varint_bytes_left;
  logic                ecn_present;
  logic [VW-1:0]       largest_reg;
  logic [VW-1:0]       delay_reg;
  logic [RL_W-1:0]     ranges_left;
  logic [VW-1:0]       range_low;
  logic [VW-1:0]       range_high;
  logic [VW-1:0]       ect0_reg;
  logic [VW-1:0]       ect1_reg;
  logic [BW-1:0]       byte_count;

  logic                active_next;
  afrp_pkg::step_t     field_step_next;
  logic [VW-1:0]       varint_acc_next;
  logic [2:0]          varint_bytes_left_next;
  logic                ecn_present_next;
  logic [VW-1:0]       largest_reg_next;
  logic [VW-1:0]       delay_reg_next;
  logic [RL_W-1:0]     ranges_left_next;
  logic [VW-1:0]       range_low_next;
  logic [VW-1:0]       range_high_next;
  logic [VW-1:0]       ect0_reg_next;
  logic [VW-1:0]       ect1_reg_next;
  logic [BW-1:0]       byte_count_next;

  // state as seen by this byte: a frame start clears everything
  logic                c_active;
  afrp_pkg::step_t     c_step;
  logic [VW-1:0]       c_acc;
  logic [2:0]          c_vbl;
  logic                c_ecn;
  logic [VW-1:0]       c_largest;
  logic [VW-1:0]       c_delay;
  logic [RL_W-1:0]     c_rl;
  logic [VW-1:0]       c_rlow;
  logic [VW-1:0]       c_rhigh;
  logic [VW-1:0]       c_ect0;
  logic [VW-1:0]       c_ect1;
  logic [BW-1:0]       c_bc;

  logic                has_rng;
  logic                has_fin;
  afrp_pkg::result_t   rng;
  afrp_pkg::result_t   fin;
  logic [RL_W-1:0]     rl_after;
  logic                range_ok;

  function automatic afrp_pkg::result_t mk_error(input afrp_pkg::err_t code);
    afrp_pkg::result_t r;
    r         = '0;
    r.kind    = afrp_pkg::KIND_ERROR;
    r.code    = code;
    r.is_last = 1'b1;
    return r;
  endfunction

  function automatic afrp_pkg::result_t mk_range(input logic [VW-1:0] lo,
                                                 input logic [VW-1:0] hi);
    afrp_pkg::result_t r;
    r             = '0;
    r.kind        = afrp_pkg::KIND_RANGE;
    r.code        = afrp_pkg::ERR_NONE;
    r.range_start = lo;
    r.range_end   = {1'b0, hi} + 63'd1;
    return r;
  endfunction

  // cleared view of the state when a new frame begins
  always_comb begin
    c_active  = frame_start | active;
    c_step    = frame_start ? afrp_pkg::STEP_TYPE : field_step;
    c_acc     = frame_start ? '0 : varint_acc;
    c_vbl     = frame_start ? '0 : varint_bytes_left;
    c_ecn     = frame_start ? 1'b0 : ecn_present;
    c_largest = frame_start ? '0 : largest_reg;
    c_delay   = frame_start ? '0 : delay_reg;
    c_rl      = frame_start ? '0 : ranges_left;
    c_rlow    = frame_start ? '0 : range_low;
    c_rhigh   = frame_start ? '0 : range_high;
    c_ect0    = frame_start ? '0 : ect0_reg;
    c_ect1    = frame_start ? '0 : ect1_reg;
    c_bc      = frame_start ? '0 : byte_count;
  end

  // byte decode and field handling
  always_comb begin
    active_next            = c_active;
    field_step_next        = c_step;
    varint_acc_next        = c_acc;
    varint_bytes_left_next = c_vbl;
    ecn_present_next       = c_ecn;
    largest_reg_next       = c_largest;
    delay_reg_next         = c_delay;
    ranges_left_next       = c_rl;
    range_low_next         = c_rlow;
    range_high_next        = c_rhigh;
    ect0_reg_next          = c_ect0;
    ect1_reg_next          = c_ect1;
    byte_count_next        = c_bc;
    has_rng                = 1'b0;
    has_fin                = 1'b0;
    rng                    = '0;
    fin                    = '0;
    rl_after               = c_rl;
    range_ok               = 1'b0;

    if (c_active) begin
      // saturating byte counter
      byte_count_next = (c_bc != {BW{1'b1}}) ? c_bc + 1'b1 : c_bc;

      // varint assembly: first byte gives the length
      if (c_vbl == 3'd0) begin
        varint_acc_next = {{(VW-6){1'b0}}, byte_value[5:0]};
        unique case (byte_value[7:6])
          2'd0:    varint_bytes_left_next = 3'd0;
          2'd1:    varint_bytes_left_next = 3'd1;
          2'd2:    varint_bytes_left_next = 3'd3;
          default: varint_bytes_left_next = 3'd7;
        endcase
      end else begin
        varint_acc_next        = {c_acc[VW-9:0], byte_value};
        varint_bytes_left_next = c_vbl - 3'd1;
      end

      // field complete
      if (varint_bytes_left_next == 3'd0) begin
        unique case (c_step)
          afrp_pkg::STEP_TYPE: begin
            if (varint_acc_next != afrp_pkg::TYPE_ACK &&
                varint_acc_next != afrp_pkg::TYPE_ACK_ECN) begin
              has_fin     = 1'b1;
              fin         = mk_error(afrp_pkg::ERR_TYPE);
              active_next = 1'b0;
            end else begin
              ecn_present_next = (varint_acc_next == afrp_pkg::TYPE_ACK_ECN);
              field_step_next  = afrp_pkg::STEP_LARGEST;
            end
          end
          afrp_pkg::STEP_LARGEST: begin
            largest_reg_next = varint_acc_next;
            field_step_next  = afrp_pkg::STEP_DELAY;
          end
          afrp_pkg::STEP_DELAY: begin
            delay_reg_next  = varint_acc_next;
            field_step_next = afrp_pkg::STEP_COUNT;
          end
          afrp_pkg::STEP_COUNT: begin
            ranges_left_next = (varint_acc_next >= VW'(MAX_RANGES)) ?
                               RL_W'(MAX_RANGES) : varint_acc_next[RL_W-1:0];
            field_step_next  = afrp_pkg::STEP_FIRST;
          end
          afrp_pkg::STEP_FIRST: begin
            if (varint_acc_next > c_largest) begin
              has_fin     = 1'b1;
              fin         = mk_error(afrp_pkg::ERR_FIRST_RANGE);
              active_next = 1'b0;
            end else if (c_rl >= RL_W'(MAX_RANGES)) begin
              has_fin     = 1'b1;
              fin         = mk_error(afrp_pkg::ERR_COUNT);
              active_next = 1'b0;
            end else begin
              range_high_next = c_largest;
              range_low_next  = c_largest - varint_acc_next;
              has_rng         = 1'b1;
              rng             = mk_range(c_largest - varint_acc_next, c_largest);
              rl_after        = c_rl;
              range_ok        = 1'b1;
            end
          end
          afrp_pkg::STEP_GAP: begin
            if ({1'b0, c_rlow} < ({1'b0, varint_acc_next} + 63'd2)) begin
              has_fin     = 1'b1;
              fin         = mk_error(afrp_pkg::ERR_GAP);
              active_next = 1'b0;
            end else begin
              range_high_next = c_rlow - varint_acc_next - 62'd2;
              field_step_next = afrp_pkg::STEP_RANGE;
            end
          end
          afrp_pkg::STEP_RANGE: begin
            if (varint_acc_next > c_rhigh) begin
              has_fin     = 1'b1;
              fin         = mk_error(afrp_pkg::ERR_RANGE);
              active_next = 1'b0;
            end else begin
              range_low_next   = c_rhigh - varint_acc_next;
              has_rng          = 1'b1;
              rng              = mk_range(c_rhigh - varint_acc_next, c_rhigh);
              rl_after         = c_rl - 1'b1;
              ranges_left_next = c_rl - 1'b1;
              range_ok         = 1'b1;
            end
          end
          afrp_pkg::STEP_ECT0: begin
            ect0_reg_next   = varint_acc_next;
            field_step_next = afrp_pkg::STEP_ECT1;
          end
          afrp_pkg::STEP_ECT1: begin
            ect1_reg_next   = varint_acc_next;
            field_step_next = afrp_pkg::STEP_CE;
          end
          afrp_pkg::STEP_CE: begin
            has_fin              = 1'b1;
            fin                  = '0;
            fin.kind             = afrp_pkg::KIND_DONE;
            fin.code             = afrp_pkg::ERR_NONE;
            fin.peak_pn          = c_largest;
            fin.reported_delay   = c_delay;
            fin.ect0_count       = c_ect0;
            fin.ect1_count       = c_ect1;
            fin.ce_count         = varint_acc_next;
            fin.consumed_bytes   = byte_count_next;
            fin.is_last          = 1'b1;
            active_next          = 1'b0;
          end
          default: begin
            active_next = 1'b0;
          end
        endcase

        // after a range: more pairs, ecn counts, or done
        if (range_ok) begin
          priority if (rl_after != '0) begin
            field_step_next = afrp_pkg::STEP_GAP;
          end else if (c_ecn) begin
            field_step_next = afrp_pkg::STEP_ECT0;
          end else begin
            has_fin            = 1'b1;
            fin                = '0;
            fin.kind           = afrp_pkg::KIND_DONE;
            fin.code           = afrp_pkg::ERR_NONE;
            fin.peak_pn        = c_largest;
            fin.reported_delay = c_delay;
            fin.ect0_count     = c_ect0;
            fin.ect1_count     = c_ect1;
            fin.ce_count       = '0;
            fin.consumed_bytes = byte_count_next;
            fin.is_last        = 1'b1;
            active_next        = 1'b0;
          end
        end
      end

      // buffer ran out before the frame finished
      if (active_next && buffer_end) begin
        has_fin     = 1'b1;
        fin         = mk_error(afrp_pkg::ERR_TRUNCATED);
        active_next = 1'b0;
      end
    end
  end

  // results of this byte, range first
  always_comb begin
    push     = '0;
    push.cnt = go ? ({1'b0, has_rng} + {1'b0, has_fin}) : 2'd0;
    push.r0  = has_rng ? rng : fin;
    push.r1  = fin;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active            <= 1'b0;
      field_step        <= afrp_pkg::STEP_TYPE;
      varint_acc        <= '0;
      varint_bytes_left <= '0;
      ecn_present       <= 1'b0;
      largest_reg       <= '0;
      delay_reg         <= '0;
      ranges_left       <= '0;
      range_low         <= '0;
      range_high        <= '0;
      ect0_reg          <= '0;
      ect1_reg          <= '0;
      byte_count        <= '0;
    end else if (go) begin
      active            <= active_next;
      field_step        <= field_step_next;
      varint_acc        <= varint_acc_next;
      varint_bytes_left <= varint_bytes_left_next;
      ecn_present       <= ecn_present_next;
      largest_reg       <= largest_reg_next;
      delay_reg         <= delay_reg_next;
      ranges_left       <= ranges_left_next;
      range_low         <= range_low_next;
      range_high        <= range_high_next;
      ect0_reg          <= ect0_reg_next;
      ect1_reg          <= ect1_reg_next;
      byte_count        <= byte_count_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/afrp_result_fifo.sv
// four-entry result queue, takes up to two results per cycle, gives one unless out_stall is high
`default_nettype none
`include "ack_frame_range_parser_top_defines.svh"

module afrp_result_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire afrp_pkg::push_t     push,
  output logic                     room,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output afrp_pkg::result_t        head
);

  afrp_pkg::result_t                    mem [afrp_pkg::QDEPTH];
  logic [afrp_pkg::QPTR_W-1:0]          wr_ptr;
  logic [afrp_pkg::QPTR_W-1:0]          rd_ptr;
  logic [afrp_pkg::QCNT_W-1:0]          count;
  logic [afrp_pkg::QCNT_W-1:0]          count_next;
  logic                                 pop;

  // room for a worst-case byte of two results
  assign room      = (count <= afrp_pkg::QCNT_W'(afrp_pkg::QDEPTH - 2));
  assign out_valid = (count != '0);
  assign head      = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    count_next = count + {1'b0, push.cnt} - {{(afrp_pkg::QCNT_W-1){1'b0}}, pop};
  end

  // storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr + 1'b1] <= push.r1;
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.cnt[afrp_pkg::QPTR_W-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  `AFRP_ASSERT_ALWAYS(a_fill_bound, count <= afrp_pkg::QCNT_W'(afrp_pkg::QDEPTH))
  `AFRP_ASSERT_IMPLY(a_push_has_room, push.cnt != 2'd0, room)
  `AFRP_ASSERT_IMPLY(a_pair_starts_with_range, push.cnt == 2'd2, push.r0.kind == afrp_pkg::KIND_RANGE)
  `AFRP_ASSERT_IMPLY(a_last_matches_kind, push.cnt != 2'd0, push.r0.is_last == (push.r0.kind != afrp_pkg::KIND_RANGE))

endmodule

`default_nettype wire

### rtl/core/ack_frame_range_parser_top.sv
// top level of the ack frame range parser: input register, decoder, result queue
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------
//   in      | in_valid / in_stall | frame_start, byte_value, buffer_end
//   out     | out_valid/out_stall | result_kind .. is_last, one result each
//
// one frame byte is taken per cycle while in_stall is low; a byte waits in the
// input register, and its results enter the result queue when it leaves that register.
// a byte can yield two results (range then done or truncation error); the
// four-entry result queue absorbs them and in_stall rises only while the queue
// cannot hold two more. synchronous reset clears the parser and the queue.
`default_nettype none

module ack_frame_range_parser_top #(
  parameter int unsigned MAX_RANGES = 256
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic         frame_start,
  input  wire logic [7:0]   byte_value,
  input  wire logic         buffer_end,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [1:0]        result_kind,
  output logic [2:0]        fault_code,
  output logic [61:0]       range_start,
  output logic [62:0]       range_end,
  output logic [61:0]       peak_pn,
  output logic [61:0]       reported_delay,
  output logic [61:0]       ect0_count,
  output logic [61:0]       ect1_count,
  output logic [61:0]       ce_count,
  output logic [12:0]       consumed_bytes,
  output logic              is_last
);

  logic              in_vld;
  logic              in_start;
  logic [7:0]        in_byte;
  logic              in_end;
  logic              room;
  logic              go;
  logic              accept;
  afrp_pkg::push_t   push;
  afrp_pkg::result_t head;

  // input register handshake
  assign go       = in_vld && room;
  assign in_stall = in_vld && !room;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (accept) begin
      in_vld <= 1'b1;
    end else if (go) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_start <= frame_start;
      in_byte  <= byte_value;
      in_end   <= buffer_end;
    end
  end

  // frame decoder
  afrp_parse #(
    .MAX_RANGES (MAX_RANGES)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .frame_start (in_start),
    .byte_value  (in_byte),
    .buffer_end  (in_end),
    .push        (push)
  );

  // result queue
  afrp_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // output fields
  assign result_kind    = head.kind;
  assign fault_code     = head.code;
  assign range_start    = head.range_start;
  assign range_end      = head.range_end;
  assign peak_pn        = head.peak_pn;
  assign reported_delay = head.reported_delay;
  assign ect0_count     = head.ect0_count;
  assign ect1_count     = head.ect1_count;
  assign ce_count       = head.ce_count;
  assign consumed_bytes = head.consumed_bytes;
  assign is_last        = head.is_last;

endmodule

`default_nettype wire

### tb/sv/tb_ack_frame_range_parser_top.sv
// testbench for the ack frame range parser: directed and random frames against a predictor
`timescale 1ns / 100ps

module tb_ack_frame_range_parser_top;

  localparam int unsigned MAX_RANGES     = 256;
  localparam int unsigned RANDOM_BYTES   = 450;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam logic [61:0] VAL_MAX        = '1;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
    logic       buf_end;
  } frame_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid    = 1'b0;
  logic        frame_start = 1'b0;
  logic [7:0]  byte_value  = 8'h00;
  logic        buffer_end  = 1'b0;
  logic        out_stall   = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  result_kind;
  logic [2:0]  fault_code;
  logic [61:0] range_start;
  logic [62:0] range_end;
  logic [61:0] peak_pn;
  logic [61:0] reported_delay;
  logic [61:0] ect0_count;
  logic [61:0] ect1_count;
  logic [61:0] ce_count;
  logic [12:0] consumed_bytes;
  logic        is_last;

  frame_byte_t         byte_q[$];
  logic [7:0]          frame_buf[$];
  afrp_pkg::result_t   ack_results_q[$];

  int unsigned bytes_total   = 0;
  int unsigned bytes_taken   = 0;
  int unsigned frames_built  = 0;
  int unsigned mismatches    = 0;
  int unsigned ranges_seen   = 0;
  int unsigned done_seen     = 0;
  int unsigned errors_seen   = 0;
  int unsigned cycle_no      = 0;
  int unsigned idle_cycles   = 0;
  logic        quiet_window;

  // predictor state
  logic            parsing;
  afrp_pkg::step_t cur_field;
  logic [61:0]     field_acc;
  logic [2:0]      field_bytes_due;
  logic            has_ecn;
  logic [61:0]     largest_pn;
  logic [61:0]     delay_val;
  int unsigned     pairs_due;
  logic [61:0]     walk_low;
  logic [61:0]     walk_high;
  logic [61:0]     ect0_val;
  logic [61:0]     ect1_val;
  logic [12:0]     frame_bytes;

  always #5 clk = ~clk;

  ack_frame_range_parser_top #(
    .MAX_RANGES(MAX_RANGES)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .frame_start   (frame_start),
    .byte_value    (byte_value),
    .buffer_end    (buffer_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .fault_code    (fault_code),
    .range_start   (range_start),
    .range_end     (range_end),
    .peak_pn       (peak_pn),
    .reported_delay(reported_delay),
    .ect0_count    (ect0_count),
    .ect1_count    (ect1_count),
    .ce_count      (ce_count),
    .consumed_bytes(consumed_bytes),
    .is_last       (is_last)
  );

  // no random idling on either side inside this window
  assign quiet_window = (cycle_no >= 200) && (cycle_no < 360);

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  task automatic clear_parser();
    parsing         = 1'b0;
    cur_field       = afrp_pkg::STEP_TYPE;
    field_acc       = '0;
    field_bytes_due = '0;
    has_ecn         = 1'b0;
    largest_pn      = '0;
    delay_val       = '0;
    pairs_due       = 0;
    walk_low        = '0;
    walk_high       = '0;
    ect0_val        = '0;
    ect1_val        = '0;
    frame_bytes     = '0;
  endtask

  task automatic push_error(input afrp_pkg::err_t code);
    afrp_pkg::result_t r;
    r         = '0;
    r.kind    = afrp_pkg::KIND_ERROR;
    r.code    = code;
    r.is_last = 1'b1;
    ack_results_q.push_back(r);
    parsing = 1'b0;
  endtask

  task automatic push_done(input logic [61:0] ce);
    afrp_pkg::result_t r;
    r                = '0;
    r.kind           = afrp_pkg::KIND_DONE;
    r.peak_pn        = largest_pn;
    r.reported_delay = delay_val;
    r.ect0_count     = ect0_val;
    r.ect1_count     = ect1_val;
    r.ce_count       = ce;
    r.consumed_bytes = frame_bytes;
    r.is_last        = 1'b1;
    ack_results_q.push_back(r);
    parsing = 1'b0;
  endtask

  // emit the current range, then move on to the next pair, the ecn counts or done
  task automatic push_range_and_advance();
    afrp_pkg::result_t r;
    r             = '0;
    r.kind        = afrp_pkg::KIND_RANGE;
    r.range_start = walk_low;
    r.range_end   = {1'b0, walk_high} + 63'd1;
    ack_results_q.push_back(r);
    if (pairs_due != 0) cur_field = afrp_pkg::STEP_GAP;
    else if (has_ecn) cur_field = afrp_pkg::STEP_ECT0;
    else push_done('0);
  endtask

  task automatic parse_ack_byte(input frame_byte_t fb);
    logic [61:0] v;
    if (fb.start) begin
      clear_parser();
      parsing = 1'b1;
    end
    if (!parsing) return;

    if (frame_bytes != 13'h1FFF) frame_bytes = frame_bytes + 13'd1;

    // varint assembly, length from the top two bits of the first byte
    if (field_bytes_due == 3'd0) begin
      field_acc = {56'd0, fb.data[5:0]};
      case (fb.data[7:6])
        2'd0: field_bytes_due = 3'd0;
        2'd1: field_bytes_due = 3'd1;
        2'd2: field_bytes_due = 3'd3;
        default: field_bytes_due = 3'd7;
      endcase
    end else begin
      field_acc       = {field_acc[53:0], fb.data};
      field_bytes_due = field_bytes_due - 3'd1;
    end

    if (field_bytes_due == 3'd0) begin
      v = field_acc;
      case (cur_field)
        afrp_pkg::STEP_TYPE: begin
          if (v != afrp_pkg::TYPE_ACK && v != afrp_pkg::TYPE_ACK_ECN)
            push_error(afrp_pkg::ERR_TYPE);
          else begin
            has_ecn   = (v == afrp_pkg::TYPE_ACK_ECN);
            cur_field = afrp_pkg::STEP_LARGEST;
          end
        end
        afrp_pkg::STEP_LARGEST: begin
          largest_pn = v;
          cur_field  = afrp_pkg::STEP_DELAY;
        end
        afrp_pkg::STEP_DELAY: begin
          delay_val = v;
          cur_field = afrp_pkg::STEP_COUNT;
        end
        afrp_pkg::STEP_COUNT: begin
          pairs_due = (v >= 62'(MAX_RANGES)) ? MAX_RANGES : int'(v);
          cur_field = afrp_pkg::STEP_FIRST;
        end
        afrp_pkg::STEP_FIRST: begin
          // first range is checked before the range count
          if (v > largest_pn) push_error(afrp_pkg::ERR_FIRST_RANGE);
          else if (pairs_due >= MAX_RANGES) push_error(afrp_pkg::ERR_COUNT);
          else begin
            walk_high = largest_pn;
            walk_low  = largest_pn - v;
            push_range_and_advance();
          end
        end
        afrp_pkg::STEP_GAP: begin
          if ({2'b00, walk_low} < {2'b00, v} + 64'd2) push_error(afrp_pkg::ERR_GAP);
          else begin
            walk_high = walk_low - v - 62'd2;
            cur_field = afrp_pkg::STEP_RANGE;
          end
        end
        afrp_pkg::STEP_RANGE: begin
          if (v > walk_high) push_error(afrp_pkg::ERR_RANGE);
          else begin
            walk_low  = walk_high - v;
            pairs_due = pairs_due - 1;
            push_range_and_advance();
          end
        end
        afrp_pkg::STEP_ECT0: begin
          ect0_val  = v;
          cur_field = afrp_pkg::STEP_ECT1;
        end
        afrp_pkg::STEP_ECT1: begin
          ect1_val  = v;
          cur_field = afrp_pkg::STEP_CE;
        end
        afrp_pkg::STEP_CE: push_done(v);
        default: parsing = 1'b0;
      endcase
    end

    // buffer ran out before the frame finished
    if (parsing && fb.buf_end) push_error(afrp_pkg::ERR_TRUNCATED);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus generation
  // ---------------------------------------------------------------------------

  task automatic queue_byte(input logic start, input logic [7:0] data, input logic buf_end);
    frame_byte_t fb;
    fb.start   = start;
    fb.data    = data;
    fb.buf_end = buf_end;
    byte_q.push_back(fb);
  endtask

  // value in [0, limit], spread over zero, the limit, small values and all magnitudes
  function automatic logic [61:0] pick_value(input logic [61:0] limit);
    logic [63:0] span;
    logic [63:0] raw;
    span = {2'b00, limit} + 64'd1;
    raw  = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return '0;
      1: return limit;
      2, 3, 4: raw = raw & 64'h3F;
      5, 6: raw = raw >> $urandom_range(8, 60);
      default: ;
    endcase
    return 62'(raw % span);
  endfunction

  // varint encoding, sometimes longer than needed
  task automatic add_varint(input logic [61:0] v);
    int unsigned code;
    int unsigned nbytes;
    logic [63:0] word;
    if (v < 62'h40) code = 0;
    else if (v < 62'h4000) code = 1;
    else if (v < 62'h4000_0000) code = 2;
    else code = 3;
    if ($urandom_range(0, 3) == 0) code = $urandom_range(code, 3);
    nbytes = 1 << code;
    word   = {2'b00, v} | (64'(code) << (8 * nbytes - 2));
    for (int i = nbytes - 1; i >= 0; i--) frame_buf.push_back(word[8 * i +: 8]);
  endtask

  // one frame, well formed or broken in one chosen way
  task automatic queue_random_frame();
    int unsigned mode;
    int unsigned n_pairs;
    int unsigned bad_pair;
    int          last_idx;
    logic        ecn;
    logic        cut_short;
    logic [61:0] largest;
    logic [61:0] first;
    logic [61:0] type_val;
    logic [61:0] g_low;
    logic [61:0] g_high;
    logic [61:0] g_gap;
    logic [61:0] g_len;

    frame_buf.delete();
    mode     = $urandom_range(0, 99);
    ecn      = 1'($urandom_range(0, 1));
    largest  = pick_value(VAL_MAX);
    n_pairs  = (mode >= 24 && mode < 40) ? $urandom_range(1, 3) : $urandom_range(0, 2);
    bad_pair = (n_pairs == 0) ? 0 : $urandom_range(0, n_pairs - 1);

    // frame type, unknown in the bad type case
    if (mode < 8) begin
      do type_val = pick_value(VAL_MAX);
      while (type_val == afrp_pkg::TYPE_ACK || type_val == afrp_pkg::TYPE_ACK_ECN);
      add_varint(type_val);
    end else begin
      add_varint(ecn ? afrp_pkg::TYPE_ACK_ECN : afrp_pkg::TYPE_ACK);
    end
    add_varint(largest);
    add_varint(pick_value(VAL_MAX));

    // range count, at or above the limit in the count error case
    if (mode >= 8 && mode < 16) add_varint(62'(MAX_RANGES) + pick_value(62'hFFFF));
    else add_varint(62'(n_pairs));

    // first range, above largest acked in the first range error case
    if (mode >= 16 && mode < 24 && largest != VAL_MAX)
      first = largest + 62'd1 + pick_value(VAL_MAX - largest - 62'd1);
    else first = pick_value(largest);
    add_varint(first);
    g_low = largest - first;

    // gap and range pairs walking down
    for (int i = 0; i < n_pairs; i++) begin
      if (mode >= 24 && mode < 32 && i == bad_pair)
        g_gap = (g_low < 62'd2) ? pick_value(VAL_MAX)
                                : g_low - 62'd1 + pick_value(VAL_MAX - g_low + 62'd1);
      else if (g_low < 62'd2) g_gap = pick_value(62'hFF);
      else g_gap = pick_value(g_low - 62'd2);
      add_varint(g_gap);
      g_high = g_low - g_gap - 62'd2;
      if (mode >= 32 && mode < 40 && i == bad_pair && g_high != VAL_MAX)
        g_len = g_high + 62'd1 + pick_value(VAL_MAX - g_high - 62'd1);
      else g_len = pick_value(g_high);
      add_varint(g_len);
      g_low = g_high - g_len;
    end

    if (ecn) begin
      add_varint(pick_value(VAL_MAX));
      add_varint(pick_value(VAL_MAX));
      add_varint(pick_value(VAL_MAX));
    end

    // buffer ends early, next frame starts early, or the whole frame goes out
    last_idx  = frame_buf.size() - 1;
    cut_short = 1'b0;
    if (mode >= 40 && mode < 52) begin
      last_idx  = $urandom_range(0, frame_buf.size() - 2);
      cut_short = 1'b1;
    end else if (mode >= 52 && mode < 58) begin
      last_idx = $urandom_range(0, frame_buf.size() - 2);
    end else begin
      cut_short = ($urandom_range(0, 3) == 0);
    end
    for (int i = 0; i <= last_idx; i++)
      queue_byte(i == 0, frame_buf[i], cut_short && (i == last_idx));

    // stray bytes between frames
    if (mode >= 58 && mode < 70)
      repeat ($urandom_range(1, 3)) queue_byte(1'b0, 8'($urandom), 1'($urandom));
    frames_built++;
  endtask

  // ---------------------------------------------------------------------------
  // input driver
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_ack_byte('{frame_start, byte_value, buffer_end});
        bytes_taken <= bytes_taken + 1;
      end
      // a stalled transaction holds its payload
      if (!(in_valid && in_stall)) begin
        if (byte_q.size() != 0 && (quiet_window || $urandom_range(0, 99) >= 13)) begin
          frame_byte_t fb;
          fb = byte_q.pop_front();
          frame_start <= fb.start;
          byte_value  <= fb.data;
          buffer_end  <= fb.buf_end;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    afrp_pkg::result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (ack_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d", $time,
                   result_kind);
          mismatches++;
        end else begin
          want = ack_results_q.pop_front();
          check_field("result_kind", want.kind, result_kind);
          check_field("fault_code", want.code, fault_code);
          check_field("range_start", want.range_start, range_start);
          check_field("range_end", want.range_end, range_end);
          check_field("peak_pn", want.peak_pn, peak_pn);
          check_field("reported_delay", want.reported_delay, reported_delay);
          check_field("ect0_count", want.ect0_count, ect0_count);
          check_field("ect1_count", want.ect1_count, ect1_count);
          check_field("ce_count", want.ce_count, ce_count);
          check_field("consumed_bytes", want.consumed_bytes, consumed_bytes);
          check_field("is_last", want.is_last, is_last);
        end
        if (result_kind == afrp_pkg::KIND_RANGE) ranges_seen++;
        else if (result_kind == afrp_pkg::KIND_DONE) done_seen++;
        else errors_seen++;
      end
      out_stall <= !quiet_window && ($urandom_range(0, 99) < 13);
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog on cycles without any transaction
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results still expected", $time,
               WATCHDOG_LIMIT, ack_results_q.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of test
  // ---------------------------------------------------------------------------

  initial begin
    clear_parser();

    // idle byte after reset, then an unknown type, then an ignored byte
    queue_byte(1'b0, 8'hFF, 1'b0);
    queue_byte(1'b1, 8'h00, 1'b0);
    queue_byte(1'b0, 8'h02, 1'b0);
    // ecn frame with one gap/range pair, a two byte zero and buffer end on the last byte
    queue_byte(1'b1, 8'h03, 1'b0);
    queue_byte(1'b0, 8'h0A, 1'b0);
    queue_byte(1'b0, 8'h00, 1'b0);
    queue_byte(1'b0, 8'h01, 1'b0);
    queue_byte(1'b0, 8'h02, 1'b0);
    queue_byte(1'b0, 8'h00, 1'b0);
    queue_byte(1'b0, 8'h06, 1'b0);
    queue_byte(1'b0, 8'h3F, 1'b0);
    queue_byte(1'b0, 8'h40, 1'b0);
    queue_byte(1'b0, 8'h00, 1'b0);
    queue_byte(1'b0, 8'h07, 1'b1);
    // buffer ends on the byte that completes the first range
    queue_byte(1'b1, 8'h03, 1'b0);
    queue_byte(1'b0, 8'h01, 1'b0);
    queue_byte(1'b0, 8'h00, 1'b0);
    queue_byte(1'b0, 8'h00, 1'b0);
    queue_byte(1'b0, 8'h00, 1'b1);
    // first range too large and range count too large together
    queue_byte(1'b1, 8'h02, 1'b0);
    queue_byte(1'b0, 8'h00, 1'b0);
    queue_byte(1'b0, 8'h00, 1'b0);
    queue_byte(1'b0, 8'h41, 1'b0);
    queue_byte(1'b0, 8'h00, 1'b0);
    queue_byte(1'b0, 8'h01, 1'b0);

    while (byte_q.size() < RANDOM_BYTES) queue_random_frame();
    bytes_total = byte_q.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken != bytes_total || ack_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes in %0d frames plus directed cases", bytes_total, frames_built);
    $display("checked %0d ranges, %0d done and %0d error results", ranges_seen, done_seen,
             errors_seen);
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/afrp_pkg.sv
rtl/core/afrp_parse.sv
rtl/core/afrp_result_fifo.sv
rtl/core/ack_frame_range_parser_top.sv
tb/sv/tb_ack_frame_range_parser_top.sv
